// ===== design/gpd_pkg.sv =====
package gpd_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_RUN    = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_GRID_WIDTH     = 3'd0;
  localparam logic [2:0] REG_GRID_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_RADIUS         = 3'd2;
  localparam logic [2:0] REG_WEIGHT_PERCENT = 3'd3;
  localparam logic [2:0] REG_LOW_LIMIT      = 3'd4;
  localparam logic [2:0] REG_HIGH_LIMIT     = 3'd5;
  localparam logic [2:0] REG_LIMIT_ENABLES  = 3'd6;
  localparam logic [2:0] REG_PASS_COUNT     = 3'd7;

  localparam int WEIGHT_MAX  = 100;
  localparam int RANK_RECIP  = 5243;
  localparam int RANK_SHIFT  = 19;
  localparam int RANK_ROUND  = 50;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         column;
    logic [7:0]         row;
    logic signed [31:0] pixel_value;
    logic               pixel_missing;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               read_missing;
    logic               status;
  } rsp_t;

endpackage

// ===== design/gpd_ram.sv =====
module gpd_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/grid_percentile_despeckle_top.sv =====
// channel  | handshake             | payload
// cmd      | cmd_valid, cmd_stall  | cmd_data (cmd_t)
// rsp      | rsp_valid, rsp_stall  | rsp_data (rsp_t)
// cfg      | cfg_we                | cfg_index, cfg_data
// Pixel write: stored when accepted in idle. Pixel read: answered from S_RDW after the grid memory read.
// Run: per pass, the grid is copied to the previous-pass memory, then each pixel goes through
// S_PIX and S_CHK; a filtered pixel then loads and sorts its window, computes the rank and selects.
// Grid memories need no clearing pass; reset clears control state only.
// rsp_stall holds the response register; cmd_stall is high while busy or a response waits.
module grid_percentile_despeckle_top
  import gpd_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  cmd_t        cmd_data,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CW      = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int RW      = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int DW      = (CW > RW ? CW : RW) + 4;
  localparam int AW      = CW + RW;
  localparam int MAX_WIN = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int NW      = $clog2(MAX_WIN + 1);
  localparam int PW      = NW + 7;
  localparam int MW      = PW + 15;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RDW    = 4'd1;
  localparam logic [3:0] S_COPY   = 4'd2;
  localparam logic [3:0] S_CFLUSH = 4'd3;
  localparam logic [3:0] S_PIX    = 4'd4;
  localparam logic [3:0] S_CHK    = 4'd5;
  localparam logic [3:0] S_WIN    = 4'd6;
  localparam logic [3:0] S_RANK   = 4'd7;
  localparam logic [3:0] S_DIV    = 4'd8;
  localparam logic [3:0] S_SEL    = 4'd9;
  localparam logic [3:0] S_PUT    = 4'd10;
  localparam logic [3:0] S_DONE   = 4'd11;

  logic [8:0]         grid_width, grid_height;
  logic [1:0]         radius;
  logic [6:0]         weight_percent;
  logic signed [31:0] low_limit, high_limit;
  logic [1:0]         limit_enables;
  logic [7:0]         pass_count;

  logic [3:0]         state;
  logic [CW-1:0]      px, wx, wx0, wx1;
  logic [RW-1:0]      py, wy, wy1;
  logic [CW-1:0]      a_col;
  logic [RW-1:0]      a_row;
  logic [7:0]         pc;
  logic               cp_v;
  logic [AW-1:0]      cp_a;
  logic               wpend, wdone;
  logic               skip_r;
  logic [NW-1:0]      cnt, k;
  logic [PW-1:0]      prod;
  logic signed [31:0] win [MAX_WIN];
  logic signed [31:0] win_ins [MAX_WIN];

  logic [DW-1:0]      w_eff, h_eff, w_last, h_last, re;
  logic [6:0]         wt_eff;
  logic               last_x, last_y;
  logic               accept, rsp_free;
  logic               run_nop;
  logic               rsp_load;
  rsp_t               rsp_next;

  logic               g_we, p_we;
  logic [AW-1:0]      g_waddr, g_raddr, p_raddr;
  logic [32:0]        g_wdata, g_rdata, p_rdata;

  logic [DW-1:0]      xe, ye, cx0, cx1, cy0, cy1;
  logic               in_range, skip;
  logic [CW-1:0]      in_col;
  logic [RW-1:0]      in_row;
  logic [PW:0]        qsum;
  logic [MW-1:0]      qm;

  assign w_eff  = (32'(grid_width) > 32'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(grid_width);
  assign h_eff  = (32'(grid_height) > 32'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(grid_height);
  assign w_last = w_eff - DW'(1);
  assign h_last = h_eff - DW'(1);
  assign re     = (32'(radius) > 32'(MAX_RADIUS)) ? DW'(MAX_RADIUS) : DW'(radius);
  assign wt_eff = (32'(weight_percent) > WEIGHT_MAX) ? 7'(WEIGHT_MAX) : weight_percent;
  assign last_x = (DW'(px) == w_last);
  assign last_y = (DW'(py) == h_last);

  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign cmd_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = cmd_valid && !cmd_stall;
  assign run_nop   = (re == '0) || (pass_count == '0) || (w_eff == '0) || (h_eff == '0);

  assign in_range = (DW'(cmd_data.column) < w_eff) && (DW'(cmd_data.row) < h_eff);
  assign in_col   = CW'(cmd_data.column);
  assign in_row   = RW'(cmd_data.row);

  assign xe  = DW'(px);
  assign ye  = DW'(py);
  assign cx0 = (xe > re) ? xe - re : '0;
  assign cx1 = (xe + re < w_last) ? xe + re : w_last;
  assign cy0 = (ye > re) ? ye - re : '0;
  assign cy1 = (ye + re < h_last) ? ye + re : h_last;
  assign skip = p_rdata[32]
             || (limit_enables[0] && (signed'(p_rdata[31:0]) < low_limit))
             || (limit_enables[1] && (high_limit < signed'(p_rdata[31:0])));

  assign qsum = {1'b0, prod} + (PW+1)'(RANK_ROUND);
  assign qm   = MW'(qsum) * MW'(RANK_RECIP);

  always_comb begin
    logic prev_lt;
    logic lt;
    prev_lt = 1'b0;
    for (int j = 0; j < MAX_WIN; j++) begin
      lt = (NW'(j) < cnt) && (signed'(p_rdata[31:0]) < win[j]);
      if (lt) begin
        win_ins[j] = prev_lt ? win[j-1] : signed'(p_rdata[31:0]);
      end else if (NW'(j) == cnt) begin
        win_ins[j] = prev_lt ? win[j-1] : signed'(p_rdata[31:0]);
      end else begin
        win_ins[j] = win[j];
      end
      prev_lt = lt;
    end
  end

  always_comb begin
    rsp_load = 1'b0;
    rsp_next = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_data.cmd == CMD_WRITE) begin
            rsp_load        = 1'b1;
            rsp_next.status = !in_range;
          end else if (cmd_data.cmd == CMD_READ) begin
            rsp_load        = !in_range;
            rsp_next.status = 1'b1;
          end else if (cmd_data.cmd == CMD_RUN) begin
            rsp_load = run_nop;
          end else begin
            rsp_load = 1'b1;
          end
        end
      end
      S_RDW: begin
        rsp_load              = rsp_free;
        rsp_next.read_value   = g_rdata[32] ? '0 : signed'(g_rdata[31:0]);
        rsp_next.read_missing = g_rdata[32];
      end
      S_DONE: begin
        rsp_load = rsp_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    g_we    = 1'b0;
    g_waddr = {in_row, in_col};
    g_wdata = cmd_data.pixel_missing ? 33'h100000000 : {1'b0, cmd_data.pixel_value};
    g_raddr = {in_row, in_col};
    p_raddr = {py, px};
    case (state)
      S_IDLE: begin
        g_we = accept && (cmd_data.cmd == CMD_WRITE) && in_range;
      end
      S_RDW: begin
        g_raddr = {a_row, a_col};
      end
      S_COPY: begin
        g_raddr = {py, px};
      end
      S_WIN: begin
        p_raddr = {wy, wx};
      end
      S_PUT: begin
        g_we    = !skip_r;
        g_waddr = {py, px};
        g_wdata = {1'b0, win[0]};
      end
      default: begin
      end
    endcase
  end

  assign p_we = cp_v;

  gpd_ram #(.WIDTH(33), .DEPTH(2 ** AW)) u_grid (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  gpd_ram #(.WIDTH(33), .DEPTH(2 ** AW)) u_prev (
    .clk(clk), .we(p_we), .waddr(cp_a), .wdata(g_rdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width     <= 9'd256;
      grid_height    <= 9'd256;
      radius         <= 2'd1;
      weight_percent <= 7'd50;
      low_limit      <= '0;
      high_limit     <= '0;
      limit_enables  <= '0;
      pass_count     <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_WIDTH:     grid_width     <= cfg_data[8:0];
        REG_GRID_HEIGHT:    grid_height    <= cfg_data[8:0];
        REG_RADIUS:         radius         <= cfg_data[1:0];
        REG_WEIGHT_PERCENT: weight_percent <= cfg_data[6:0];
        REG_LOW_LIMIT:      low_limit      <= signed'(cfg_data);
        REG_HIGH_LIMIT:     high_limit     <= signed'(cfg_data);
        REG_LIMIT_ENABLES:  limit_enables  <= cfg_data[1:0];
        REG_PASS_COUNT:     pass_count     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cp_a <= {py, px};
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      cp_v      <= 1'b0;
      wpend     <= 1'b0;
      wdone     <= 1'b0;
      px        <= '0;
      py        <= '0;
      pc        <= '0;
      cnt       <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
        rsp_data  <= rsp_next;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      cp_v <= (state == S_COPY);
      case (state)
        S_IDLE: begin
          if (accept) begin
            a_col <= in_col;
            a_row <= in_row;
            if (cmd_data.cmd == CMD_READ && in_range) begin
              state <= S_RDW;
            end else if (cmd_data.cmd == CMD_RUN && !run_nop) begin
              pc    <= pass_count;
              px    <= '0;
              py    <= '0;
              state <= S_COPY;
            end
          end
        end
        S_RDW: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        S_COPY: begin
          if (last_x) begin
            px <= '0;
            if (last_y) begin
              py    <= '0;
              state <= S_CFLUSH;
            end else begin
              py <= py + RW'(1);
            end
          end else begin
            px <= px + CW'(1);
          end
        end
        S_CFLUSH: begin
          state <= S_PIX;
        end
        S_PIX: begin
          state <= S_CHK;
        end
        S_CHK: begin
          wx0    <= CW'(cx0);
          wx1    <= CW'(cx1);
          wy1    <= RW'(cy1);
          wx     <= CW'(cx0);
          wy     <= RW'(cy0);
          cnt    <= '0;
          wpend  <= 1'b0;
          wdone  <= 1'b0;
          skip_r <= skip;
          state  <= skip ? S_PUT : S_WIN;
        end
        S_WIN: begin
          if (wpend && !p_rdata[32]) begin
            win <= win_ins;
            cnt <= cnt + NW'(1);
          end
          wpend <= !wdone;
          if (!wdone) begin
            if (wx == wx1) begin
              wx <= wx0;
              if (wy == wy1) begin
                wdone <= 1'b1;
              end else begin
                wy <= wy + RW'(1);
              end
            end else begin
              wx <= wx + CW'(1);
            end
          end else if (!wpend) begin
            state <= S_RANK;
          end
        end
        S_RANK: begin
          prod  <= PW'(cnt - NW'(1)) * PW'(wt_eff);
          state <= S_DIV;
        end
        S_DIV: begin
          k     <= NW'(qm >> RANK_SHIFT);
          state <= S_SEL;
        end
        S_SEL: begin
          if (k != '0) begin
            for (int j = 0; j < MAX_WIN - 1; j++) begin
              win[j] <= win[j+1];
            end
            k <= k - NW'(1);
          end else begin
            state <= S_PUT;
          end
        end
        S_PUT: begin
          if (last_x) begin
            px <= '0;
            if (last_y) begin
              py <= '0;
              if (pc == 8'd1) begin
                state <= S_DONE;
              end else begin
                pc    <= pc - 8'd1;
                state <= S_COPY;
              end
            end else begin
              py    <= py + RW'(1);
              state <= S_PIX;
            end
          end else begin
            px    <= px + CW'(1);
            state <= S_PIX;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
